>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the RTL. They expand to nothing in synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// check a property at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// check that an antecedent implies a consequent in the same cycle
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// check that an antecedent implies a consequent in the next cycle
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(label, clk, rst, prop)
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared sizes, codes and types of the linear probing hash table.
// ----------------------------------------------------------------------------
`default_nettype none

package lpht_pkg;

   // table geometry
   localparam int SLOTS = 97;
   localparam int IDX_W = $clog2(SLOTS);

   // field widths
   localparam int FUNC_W   = 2;
   localparam int KEY_W    = 31;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 3;

   // operation codes
   localparam logic [FUNC_W-1:0] FUNC_PUT    = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_GET    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_INSERTED = 3'd0;
   localparam logic [STATUS_W-1:0] ST_UPDATED  = 3'd1;
   localparam logic [STATUS_W-1:0] ST_HIT      = 3'd2;
   localparam logic [STATUS_W-1:0] ST_MISS     = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FULL     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_REMOVED  = 3'd5;

   // value returned on a miss
   localparam logic signed [VALUE_W-1:0] MISS_VALUE = -32'sd100;

   // slot write request from the sequencer to the slot store
   typedef struct packed {
      logic             ins;   // set valid, write key and value
      logic             upd;   // write value only
      logic             clr;   // clear valid
      logic [IDX_W-1:0] idx;
   } wr_req_type;

endpackage

`default_nettype wire

>>> rtl/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Key/value table with open addressing and linear probing.
// ----------------------------------------------------------------------------
// One request at a time. After a request word is taken the key is reduced
// mod SLOTS by a reciprocal multiply and a multiply-subtract, the result
// loading the home slot, then the probe walks from the home slot upward
// with wrap-around; each probe is one read of the slot memory followed by
// the key compare. The response word is offered on the next cycle and a new
// request is taken the cycle after the response leaves. The longest walk
// covers all SLOTS slots (a put into a full table). An unused operation
// code answers miss on the cycle after it is taken.
// Valid flags are flops cleared by reset, so no clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module linear_probe_hash_table (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_stall,
   input  wire logic [lpht_pkg::FUNC_W-1:0]           req_func,
   input  wire logic [lpht_pkg::KEY_W-1:0]            req_key,
   input  wire logic signed [lpht_pkg::VALUE_W-1:0]   req_value,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_stall,
   output logic [lpht_pkg::STATUS_W-1:0]              rsp_status,
   output logic signed [lpht_pkg::VALUE_W-1:0]        rsp_read_value
);

   typedef enum logic [4:0] {
      S_IDLE  = 5'b00001,
      S_MOD   = 5'b00010,
      S_READ  = 5'b00100,
      S_CHECK = 5'b01000,
      S_RESP  = 5'b10000
   } state_type;

   localparam logic [lpht_pkg::IDX_W-1:0] LAST_IDX = lpht_pkg::IDX_W'(lpht_pkg::SLOTS - 1);

   state_type                           state_ff, state_in;
   logic [lpht_pkg::FUNC_W-1:0]         func_ff, func_in;
   logic [lpht_pkg::KEY_W-1:0]          key_ff, key_in;
   logic signed [lpht_pkg::VALUE_W-1:0] value_ff, value_in;
   logic [lpht_pkg::IDX_W-1:0]          idx_ff, idx_in;
   logic [lpht_pkg::IDX_W-1:0]          n_ff, n_in;
   logic                                removed_ff, removed_in;
   logic [lpht_pkg::STATUS_W-1:0]       status_ff, status_in;
   logic signed [lpht_pkg::VALUE_W-1:0] rval_ff, rval_in;

   logic                                mod_start;
   logic                                mod_done;
   logic [lpht_pkg::IDX_W-1:0]          mod_rem;
   lpht_pkg::wr_req_type                wr;
   logic                                rd_en;
   logic                                rd_valid;
   logic [lpht_pkg::KEY_W-1:0]          rd_key;
   logic signed [lpht_pkg::VALUE_W-1:0] rd_value;
   logic                                accept;
   logic                                last_probe;
   logic                                key_hit;
   logic [lpht_pkg::IDX_W-1:0]          idx_next;

   lpht_mod u_mod (
      .clock (clock),
      .reset (reset),
      .start (mod_start),
      .key   (key_ff),
      .done  (mod_done),
      .rem   (mod_rem)
   );

   lpht_store u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_en    (rd_en),
      .rd_idx   (idx_ff),
      .wr       (wr),
      .wr_key   (key_ff),
      .wr_value (value_ff),
      .rd_valid (rd_valid),
      .rd_key   (rd_key),
      .rd_value (rd_value)
   );

   assign accept     = req_valid && !req_stall;
   assign last_probe = (n_ff == LAST_IDX);
   assign key_hit    = rd_valid && (rd_key == key_ff);
   assign idx_next   = (idx_ff == LAST_IDX) ? '0 : idx_ff + lpht_pkg::IDX_W'(1);
   assign rd_en      = (state_ff == S_READ);
   assign mod_start  = (state_ff == S_MOD) && !mod_done && (n_ff == '0) && !removed_ff;

   // sequence one request: reduce key, walk the probe chain, answer
   always_comb begin
      state_in   = state_ff;
      func_in    = func_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      idx_in     = idx_ff;
      n_in       = n_ff;
      removed_in = removed_ff;
      status_in  = status_ff;
      rval_in    = rval_ff;
      wr         = '{ins: 1'b0, upd: 1'b0, clr: 1'b0, idx: idx_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               func_in    = req_func;
               key_in     = req_key;
               value_in   = req_value;
               n_in       = '0;
               removed_in = 1'b0;
               if (req_func == lpht_pkg::FUNC_PUT || req_func == lpht_pkg::FUNC_GET ||
                   req_func == lpht_pkg::FUNC_REMOVE) begin
                  state_in = S_MOD;
               end else begin
                  status_in = lpht_pkg::ST_MISS;
                  rval_in   = lpht_pkg::MISS_VALUE;
                  state_in  = S_RESP;
               end
            end
         end

         S_MOD: begin
            // hold until the home slot is known; the start pulse flags itself
            if (mod_start) begin
               removed_in = 1'b1;
            end
            if (mod_done) begin
               idx_in     = mod_rem;
               n_in       = '0;
               removed_in = 1'b0;
               state_in   = S_READ;
            end
         end

         S_READ: begin
            state_in = S_CHECK;
         end

         S_CHECK: begin
            state_in = S_READ;
            idx_in   = idx_next;
            n_in     = n_ff + lpht_pkg::IDX_W'(1);
            case (func_ff)
               lpht_pkg::FUNC_PUT: begin
                  if (!rd_valid) begin
                     wr.ins    = 1'b1;
                     status_in = lpht_pkg::ST_INSERTED;
                     rval_in   = '0;
                     state_in  = S_RESP;
                  end else if (key_hit) begin
                     wr.upd    = 1'b1;
                     status_in = lpht_pkg::ST_UPDATED;
                     rval_in   = '0;
                     state_in  = S_RESP;
                  end else if (last_probe) begin
                     status_in = lpht_pkg::ST_FULL;
                     rval_in   = '0;
                     state_in  = S_RESP;
                  end
               end
               lpht_pkg::FUNC_GET: begin
                  if (key_hit) begin
                     status_in = lpht_pkg::ST_HIT;
                     rval_in   = rd_value;
                     state_in  = S_RESP;
                  end else if (!rd_valid || last_probe) begin
                     status_in = lpht_pkg::ST_MISS;
                     rval_in   = lpht_pkg::MISS_VALUE;
                     state_in  = S_RESP;
                  end
               end
               default: begin
                  // remove: clear every match up to the first empty slot
                  if (key_hit) begin
                     wr.clr     = 1'b1;
                     removed_in = 1'b1;
                  end
                  if (!rd_valid || last_probe) begin
                     if (key_hit || removed_ff) begin
                        status_in = lpht_pkg::ST_REMOVED;
                        rval_in   = '0;
                     end else begin
                        status_in = lpht_pkg::ST_MISS;
                        rval_in   = lpht_pkg::MISS_VALUE;
                     end
                     state_in = S_RESP;
                  end
               end
            endcase
         end

         S_RESP: begin
            if (!rsp_stall) begin
               state_in   = S_IDLE;
               n_in       = '0;
               removed_in = 1'b0;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         n_ff       <= '0;
         removed_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         n_ff       <= n_in;
         removed_ff <= removed_in;
      end
      func_ff   <= func_in;
      key_ff    <= key_in;
      value_ff  <= value_in;
      idx_ff    <= idx_in;
      status_ff <= status_in;
      rval_ff   <= rval_in;
   end

   assign req_stall      = (state_ff != S_IDLE);
   assign rsp_valid      = (state_ff == S_RESP);
   assign rsp_status     = status_ff;
   assign rsp_read_value = rval_ff;

   // checks
   `ASSERT_IMPLIES(a_mod_done_in_mod, clock, reset, mod_done, state_ff == S_MOD)
   `ASSERT_IMPLIES(a_probe_idx_range, clock, reset, state_ff == S_CHECK, idx_ff <= LAST_IDX)
   `ASSERT_NEXT(a_accept_leaves_idle, clock, reset, accept, state_ff != S_IDLE)
   `ASSERT_IMPLIES(a_single_write, clock, reset, 1'b1, $countones({wr.ins, wr.upd, wr.clr}) <= 1)

endmodule

`default_nettype wire

>>> rtl/lpht_mod.sv
// ----------------------------------------------------------------------------
// lpht_mod
// Key mod SLOTS unit: reciprocal multiply, then multiply-back and subtract.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_mod (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [lpht_pkg::KEY_W-1:0]      key,
   output logic                                 done,
   output logic [lpht_pkg::IDX_W-1:0]           rem
);

   // reciprocal of SLOTS scaled by 2^(KEY_W+IDX_W), rounded up; exact for every key
   localparam int SHIFT   = lpht_pkg::KEY_W + lpht_pkg::IDX_W;
   localparam int RECIP_W = 32;
   localparam logic [RECIP_W-1:0] RECIP =
      RECIP_W'(((64'd1 << SHIFT) + 64'(lpht_pkg::SLOTS) - 64'd1) / 64'(lpht_pkg::SLOTS));
   localparam int PROD_W  = lpht_pkg::KEY_W + RECIP_W;
   localparam int QUO_W   = PROD_W - SHIFT;

   logic                          mul_ff, mul_in;
   logic                          done_ff, done_in;
   logic [lpht_pkg::KEY_W-1:0]    key_ff, key_in;
   logic [PROD_W-1:0]             prod_ff, prod_in;
   logic [lpht_pkg::IDX_W-1:0]    rem_ff, rem_in;
   logic [QUO_W-1:0]              quo;
   logic [lpht_pkg::KEY_W-1:0]    back;
   logic [lpht_pkg::KEY_W-1:0]    diff;

   // take the quotient from the product and subtract quotient times SLOTS
   always_comb begin
      quo  = prod_ff[PROD_W-1:SHIFT];
      back = lpht_pkg::KEY_W'(quo) * lpht_pkg::KEY_W'(lpht_pkg::SLOTS);
      diff = key_ff - back;
   end

   // multiply when started, then form the remainder from the registered product
   always_comb begin
      mul_in  = 1'b0;
      done_in = 1'b0;
      key_in  = key_ff;
      prod_in = prod_ff;
      rem_in  = rem_ff;
      if (mul_ff) begin
         rem_in  = diff[lpht_pkg::IDX_W-1:0];
         done_in = 1'b1;
      end else if (start) begin
         mul_in  = 1'b1;
         key_in  = key;
         prod_in = PROD_W'(key) * PROD_W'(RECIP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
      key_ff  <= key_in;
      prod_ff <= prod_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign rem  = rem_ff;

endmodule

`default_nettype wire

>>> rtl/lpht_store.sv
// ----------------------------------------------------------------------------
// lpht_store
// Slot store: valid flags in flops, keys and values in a memory with one read
// port and one write port, with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module lpht_store (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  rd_en,
   input  wire logic [lpht_pkg::IDX_W-1:0]            rd_idx,
   input  wire lpht_pkg::wr_req_type                  wr,
   input  wire logic [lpht_pkg::KEY_W-1:0]            wr_key,
   input  wire logic signed [lpht_pkg::VALUE_W-1:0]   wr_value,
   output logic                                       rd_valid,
   output logic [lpht_pkg::KEY_W-1:0]                 rd_key,
   output logic signed [lpht_pkg::VALUE_W-1:0]        rd_value
);

   logic [lpht_pkg::SLOTS-1:0]          valid_ff;
   logic [lpht_pkg::KEY_W-1:0]          key_mem   [lpht_pkg::SLOTS];
   logic signed [lpht_pkg::VALUE_W-1:0] value_mem [lpht_pkg::SLOTS];
   logic                                rd_valid_ff;
   logic [lpht_pkg::KEY_W-1:0]          rd_key_ff;
   logic signed [lpht_pkg::VALUE_W-1:0] rd_value_ff;

   // valid flags: clear all at reset, set on insert, drop on remove
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (wr.ins) begin
         valid_ff[wr.idx] <= 1'b1;
      end else if (wr.clr) begin
         valid_ff[wr.idx] <= 1'b0;
      end
   end

   // key and value memory writes
   always_ff @(posedge clock) begin
      if (wr.ins) begin
         key_mem[wr.idx] <= wr_key;
      end
      if (wr.ins || wr.upd) begin
         value_mem[wr.idx] <= wr_value;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_valid_ff <= valid_ff[rd_idx];
         rd_key_ff   <= key_mem[rd_idx];
         rd_value_ff <= value_mem[rd_idx];
      end
   end

   assign rd_valid = rd_valid_ff;
   assign rd_key   = rd_key_ff;
   assign rd_value = rd_value_ff;

endmodule

`default_nettype wire

>>> tb/sv/linear_probe_hash_table_test.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_test
// Self-checking bench for the linear probing key/value table.
// ----------------------------------------------------------------------------
// A queue of request words is built at time zero. It starts with a hand-made
// run through colliding keys, wrap-around, lost keys and removal of duplicate
// copies. Random traffic over a small pool of colliding keys follows. A final
// phase fills the table past capacity and then removes the fill keys. A
// clocked driver feeds the words to the block with random pauses. A clocked
// monitor applies random stall and compares each reply word with the oldest
// prediction from a local shadow of the table.
// ----------------------------------------------------------------------------

module linear_probe_hash_table_test;
   timeunit 1ns;
   timeprecision 1ps;

   // operation code the block does not implement
   localparam logic [lpht_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   localparam int POOL_SIZE    = 16;
   localparam int RANDOM_COUNT = 1030;
   localparam int FILL_COUNT   = 110;
   // longest request: key reduction, a full walk of the table, reply word
   localparam int DRAIN_CYCLES = 300;

   typedef struct {
      logic [lpht_pkg::FUNC_W-1:0]         func;
      logic [lpht_pkg::KEY_W-1:0]          key;
      logic signed [lpht_pkg::VALUE_W-1:0] value;
      bit                                  wait_idle;  // hold until all replies are in
   } table_op_type;

   typedef struct {
      logic [lpht_pkg::STATUS_W-1:0]       status;
      logic signed [lpht_pkg::VALUE_W-1:0] read_value;
   } table_reply_type;

   logic                                   clock = 1'b0;
   logic                                   reset = 1'b1;
   logic                                   req_valid = 1'b0;
   logic                                   req_stall;
   logic [lpht_pkg::FUNC_W-1:0]            req_func = lpht_pkg::FUNC_PUT;
   logic [lpht_pkg::KEY_W-1:0]             req_key = '0;
   logic signed [lpht_pkg::VALUE_W-1:0]    req_value = '0;
   logic                                   rsp_valid;
   logic                                   rsp_stall = 1'b0;
   logic [lpht_pkg::STATUS_W-1:0]          rsp_status;
   logic signed [lpht_pkg::VALUE_W-1:0]    rsp_read_value;

   // shadow copy of the table
   bit                                     shadow_used [lpht_pkg::SLOTS];
   logic [lpht_pkg::KEY_W-1:0]             shadow_key [lpht_pkg::SLOTS];
   logic signed [lpht_pkg::VALUE_W-1:0]    shadow_value [lpht_pkg::SLOTS];

   table_op_type                           pending_ops[$];
   table_reply_type                        expected_replies[$];
   table_op_type                           cur_op;
   int                                     ops_total = 0;
   int                                     ops_accepted = 0;
   int                                     errors = 0;
   int                                     status_tally [6];

   linear_probe_hash_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_key        (req_key),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_read_value (rsp_read_value)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one operation to the shadow table and return the reply it earns.
   function automatic table_reply_type probe_table(input table_op_type op);
      table_reply_type reply;
      int unsigned     slot;
      bit              cleared;
      slot = int'(op.key % lpht_pkg::SLOTS);
      cleared = 1'b0;
      reply.status = lpht_pkg::ST_MISS;
      reply.read_value = lpht_pkg::MISS_VALUE;
      case (op.func)
         lpht_pkg::FUNC_PUT: begin
            reply.status = lpht_pkg::ST_FULL;
            reply.read_value = '0;
            for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
               if (!shadow_used[slot]) begin
                  shadow_used[slot] = 1'b1;
                  shadow_key[slot] = op.key;
                  shadow_value[slot] = op.value;
                  reply.status = lpht_pkg::ST_INSERTED;
                  break;
               end
               if (shadow_key[slot] == op.key) begin
                  shadow_value[slot] = op.value;
                  reply.status = lpht_pkg::ST_UPDATED;
                  break;
               end
               slot = (slot + 1 == lpht_pkg::SLOTS) ? 0 : slot + 1;
            end
         end
         lpht_pkg::FUNC_GET: begin
            for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
               if (!shadow_used[slot])
                  break;
               if (shadow_key[slot] == op.key) begin
                  reply.status = lpht_pkg::ST_HIT;
                  reply.read_value = shadow_value[slot];
                  break;
               end
               slot = (slot + 1 == lpht_pkg::SLOTS) ? 0 : slot + 1;
            end
         end
         lpht_pkg::FUNC_REMOVE: begin
            // clear every copy up to the first hole, no tombstones
            for (int n = 0; n < lpht_pkg::SLOTS; n++) begin
               if (!shadow_used[slot])
                  break;
               if (shadow_key[slot] == op.key) begin
                  shadow_used[slot] = 1'b0;
                  cleared = 1'b1;
               end
               slot = (slot + 1 == lpht_pkg::SLOTS) ? 0 : slot + 1;
            end
            if (cleared) begin
               reply.status = lpht_pkg::ST_REMOVED;
               reply.read_value = '0;
            end
         end
         default: begin
         end
      endcase
      return reply;
   endfunction

   task automatic queue_op(input logic [lpht_pkg::FUNC_W-1:0] func,
                           input logic [lpht_pkg::KEY_W-1:0] key,
                           input logic signed [lpht_pkg::VALUE_W-1:0] value,
                           input bit wait_idle);
      table_op_type op;
      op.func = func;
      op.key = key;
      op.value = value;
      op.wait_idle = wait_idle;
      pending_ops.push_back(op);
   endtask

   // Build the whole request stream up front.
   initial begin : build_stimulus
      logic [lpht_pkg::KEY_W-1:0]  key_pool [POOL_SIZE];
      logic [lpht_pkg::KEY_W-1:0]  fill_keys [FILL_COUNT];
      logic [lpht_pkg::KEY_W-1:0]  swap_key;
      logic [lpht_pkg::KEY_W-1:0]  fill_base;
      logic [lpht_pkg::KEY_W-1:0]  k;
      logic [lpht_pkg::FUNC_W-1:0] f;
      int                          pick;
      int                          j;

      // extremes of key and value, update in place
      queue_op(lpht_pkg::FUNC_PUT, 31'd0, 32'sh7fff_ffff, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'h7fff_ffff, 32'sh8000_0000, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd0, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'h7fff_ffff, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'd0, -32'sd1, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd0, 32'sd0, 1'b0);
      // collisions on home slot 0, then a chain that wraps from the top slot
      queue_op(lpht_pkg::FUNC_PUT, 31'd97, 32'sd5, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'd194, 32'sd6, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'd96, 32'sd7, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'd193, 32'sd8, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd193, 32'sd0, 1'b0);
      // cut the chain: the key past the hole goes missing, then gets a twin
      queue_op(lpht_pkg::FUNC_REMOVE, 31'd97, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd194, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'd194, 32'sd9, 1'b0);
      queue_op(lpht_pkg::FUNC_REMOVE, 31'd194, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd194, 32'sd0, 1'b0);
      // misses (absent key, empty home, unused code), remove, lost key, hit
      queue_op(lpht_pkg::FUNC_REMOVE, 31'd12345, 32'sd0, 1'b0);
      queue_op(FUNC_UNUSED, 31'h7fff_ffff, -32'sd1, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd5, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_REMOVE, 31'd0, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'd193, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_PUT, 31'h5555_5555, 32'sd0, 1'b0);
      queue_op(lpht_pkg::FUNC_GET, 31'h5555_5555, 32'sd0, 1'b0);

      // pool of keys that share four home slots, so chains grow long
      for (int i = 0; i < POOL_SIZE; i++)
         key_pool[i] = 31'((i % 4) * 23 + 97 * $urandom_range(0, 22_000_000));

      // random traffic, mostly on the pool, with fresh keys and unused codes
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         pick = $urandom_range(0, 99);
         k = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         if (pick < 45)
            f = lpht_pkg::FUNC_PUT;
         else if (pick < 80)
            f = lpht_pkg::FUNC_GET;
         else if (pick < 95)
            f = lpht_pkg::FUNC_REMOVE;
         else
            f = FUNC_UNUSED;
         if ($urandom_range(0, 99) < ((f == lpht_pkg::FUNC_PUT) ? 4 : 15))
            k = 31'($urandom());
         queue_op(f, k, $urandom(), (i % 250) == 0);
         if (i % 100 == 99)
            key_pool[$urandom_range(0, POOL_SIZE - 1)] =
               31'($urandom_range(0, 96) + 97 * $urandom_range(0, 22_000_000));
      end

      // fill past capacity with distinct keys, then probe the full table
      fill_base = 31'(31'h4000_0000 + $urandom_range(0, 31'h1fff_ffff));
      for (int i = 0; i < FILL_COUNT; i++) begin
         fill_keys[i] = 31'(fill_base + i * 53);
         queue_op(lpht_pkg::FUNC_PUT, fill_keys[i], $urandom(), i == 0);
      end
      for (int i = 0; i < 10; i++)
         queue_op(lpht_pkg::FUNC_GET, fill_keys[$urandom_range(0, FILL_COUNT - 1)],
                  32'sd0, 1'b0);
      for (int i = 0; i < 5; i++) begin
         queue_op(lpht_pkg::FUNC_GET, 31'($urandom_range(0, 1_000_000)), 32'sd0, 1'b0);
         queue_op(lpht_pkg::FUNC_REMOVE, 31'($urandom_range(0, 1_000_000)), 32'sd0, 1'b0);
      end
      queue_op(lpht_pkg::FUNC_PUT, 31'($urandom_range(0, 1_000_000)), $urandom(), 1'b0);

      // remove the fill keys again in random order
      for (int i = FILL_COUNT - 1; i > 0; i--) begin
         j = $urandom_range(0, i);
         swap_key = fill_keys[i];
         fill_keys[i] = fill_keys[j];
         fill_keys[j] = swap_key;
      end
      for (int i = 0; i < FILL_COUNT; i++)
         queue_op(lpht_pkg::FUNC_REMOVE, fill_keys[i], $urandom(), 1'b0);
      for (int i = 0; i < 5; i++)
         queue_op(lpht_pkg::FUNC_GET, fill_keys[i], 32'sd0, 1'b0);

      ops_total = pending_ops.size();
   end

   // Drive request words; predict each one as it is taken.
   always @(posedge clock) begin : drive_requests
      int pause_left;
      int calm_left;
      if (reset) begin
         req_valid <= 1'b0;
         pause_left = 0;
         calm_left = 0;
      end else if (!(req_valid && req_stall)) begin
         if (req_valid) begin
            expected_replies.push_back(probe_table(cur_op));
            ops_accepted++;
            if (calm_left != 0) begin
               calm_left--;
               pause_left = 0;
            end else begin
               pause_left = $urandom_range(0, 6);
               if ($urandom_range(0, 39) == 0)
                  calm_left = 30;
            end
         end
         if (pause_left == 0 && pending_ops.size() != 0 &&
             (!pending_ops[0].wait_idle || expected_replies.size() == 0)) begin
            cur_op = pending_ops.pop_front();
            req_valid <= 1'b1;
            req_func <= cur_op.func;
            req_key <= cur_op.key;
            req_value <= cur_op.value;
         end else begin
            if (pause_left != 0)
               pause_left--;
            req_valid <= 1'b0;
         end
      end
   end

   // Take reply words under random stall and check them in order.
   always @(posedge clock) begin : check_replies
      table_reply_type want;
      int              hold_left;
      int              calm_left;
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left = 0;
         calm_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_replies.size() == 0) begin
               errors++;
               $display("%0t: reply word with nothing expected: status %0d read_value %0d",
                        $time, rsp_status, rsp_read_value);
            end else begin
               want = expected_replies.pop_front();
               if (rsp_status !== want.status) begin
                  errors++;
                  $display("%0t: status expected %0d, got %0d",
                           $time, want.status, rsp_status);
               end
               if (rsp_read_value !== want.read_value) begin
                  errors++;
                  $display("%0t: read_value expected %0d, got %0d",
                           $time, want.read_value, rsp_read_value);
               end
               if (want.status < 6)
                  status_tally[want.status]++;
            end
            if (calm_left != 0) begin
               calm_left--;
               hold_left = 0;
            end else begin
               hold_left = $urandom_range(0, 6);
               if ($urandom_range(0, 39) == 0)
                  calm_left = 30;
            end
         end else if (hold_left != 0) begin
            hold_left--;
         end
         rsp_stall <= (hold_left != 0);
      end
   end

   // Release reset, wait for the stream to finish, report.
   initial begin : run_control
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      while (ops_total == 0 || ops_accepted != ops_total)
         @(posedge clock);
      while (expected_replies.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("ran %0d operations: %0d inserted, %0d updated, %0d hits, %0d misses",
               ops_accepted, status_tally[lpht_pkg::ST_INSERTED],
               status_tally[lpht_pkg::ST_UPDATED], status_tally[lpht_pkg::ST_HIT],
               status_tally[lpht_pkg::ST_MISS]);
      $display("%0d puts met a full table, %0d removes cleared entries",
               status_tally[lpht_pkg::ST_FULL], status_tally[lpht_pkg::ST_REMOVED]);
      if (errors == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin : watchdog
      #16ms;
      $display("timeout waiting for the block");
      $display("== FAIL ==");
      $finish;
   end

endmodule
